### rtl/gog_pkg.sv
package gog_pkg;

  // Fixed width of the row fields on the channels.
  localparam int unsigned ROW_DATA_W = 64;

  // Result queue: one item may push up to three rows.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_IDX_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;
  localparam int unsigned MAX_PUSH    = 3;

  // Bit 0 of the shifted row is never spread.
  localparam int unsigned BORDER = 1;

  typedef struct packed {
    logic [ROW_DATA_W-1:0] bits;
    logic                  last;
  } outline_entry_t;

endpackage

### rtl/gog_ifs.sv
interface gog_row_if;
  import gog_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ROW_DATA_W-1:0] row_bits;
  logic                  row_is_last;

  modport source (output valid, output row_bits, output row_is_last, input ready);
  modport sink   (input valid, input row_bits, input row_is_last, output ready);
endinterface

interface gog_outline_if;
  import gog_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ROW_DATA_W-1:0] outline_bits;
  logic                  outline_last;

  modport source (output valid, output outline_bits, output outline_last, input ready);
  modport sink   (input valid, input outline_bits, input outline_last, output ready);
endinterface

### rtl/glyph_outline_generator_core.sv
// Glyph outline generator.
// A glyph enters on row_in one bitmap row per item, left-aligned (bit
// ROW_WIDTH-1 is the leftmost pixel), with row_is_last on its final row.
// The block emits a one-pixel outline on outline_out: one row per input
// row, plus two flush rows after the final row, so H input rows give H+2
// outline rows; outline_last marks the last of them.
// Both channels use valid/ready; an item moves when both are high.
// Flow: an accepted row's outline row is written into the result queue and
// leaves on outline_out after the rows queued ahead of it. Rows are taken
// at one per cycle while the receiver keeps up; a final row pushes three
// results, so row_in then stalls while the flush rows drain. The rate is
// set by the 4-entry queue: row_in is ready while it holds at most one row.
// A stalled receiver simply holds the queue head; row_in keeps accepting
// until the queue can no longer take a final row's three results.
// Reset (rst, synchronous, active high) empties the queue and clears the
// row history, so the block starts on a fresh glyph.
// The outline logic itself is a few shifts, ORs and masks on the accepted
// row and the two previous spread rows.
module glyph_outline_generator_core #(
  parameter int unsigned ROW_WIDTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  gog_row_if.sink         row_in,
  gog_outline_if.source   outline_out
);
  import gog_pkg::*;

  // Row history, cleared after each final row.
  logic [ROW_WIDTH-1:0] spread_prev1;
  logic [ROW_WIDTH-1:0] spread_prev2;
  logic [ROW_WIDTH-1:0] shifted_prev;

  // Result queue.
  outline_entry_t         queue [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr_ptr;
  logic [QUEUE_IDX_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic [QUEUE_CNT_W-1:0] count_next;

  logic                 in_acc;
  logic                 out_acc;
  logic [ROW_WIDTH-1:0] row;
  logic [ROW_WIDTH-1:0] shifted;
  logic [ROW_WIDTH-1:0] kept;
  logic [ROW_WIDTH-1:0] spread;
  logic [ROW_WIDTH-1:0] res0;
  logic [ROW_WIDTH-1:0] res1;
  logic [ROW_WIDTH-1:0] res2;
  logic [1:0]           push_n;

  // Accept while the queue can still absorb a final row's three results.
  assign row_in.ready = (count <= QUEUE_CNT_W'(QUEUE_DEPTH - MAX_PUSH));
  assign in_acc       = row_in.valid && row_in.ready;

  assign outline_out.valid        = (count != '0);
  assign outline_out.outline_bits = queue[rd_ptr].bits;
  assign outline_out.outline_last = queue[rd_ptr].last;
  assign out_acc                  = outline_out.valid && outline_out.ready;

  // Outline math: shift right by the border, drop bit 0, spread to both
  // neighbours (the left spread falls off the top edge).
  always_comb begin
    row     = row_in.row_bits[ROW_WIDTH-1:0];
    shifted = row >> BORDER;
    kept    = shifted & ~ROW_WIDTH'(1);
    spread  = kept | (kept << 1) | (kept >> 1);
    res0    = (spread_prev2 | spread_prev1 | spread) & ~shifted_prev;
    res1    = (spread_prev1 | spread) & ~shifted;
    res2    = spread;
    push_n  = row_in.row_is_last ? 2'(MAX_PUSH) : 2'd1;
  end

  always_comb begin
    count_next = count;
    if (in_acc) begin
      count_next = count_next + QUEUE_CNT_W'(push_n);
    end
    if (out_acc) begin
      count_next = count_next - QUEUE_CNT_W'(1);
    end
  end

  // Control state and row history.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
      spread_prev1 <= '0;
      spread_prev2 <= '0;
      shifted_prev <= '0;
    end else begin
      count <= count_next;
      if (out_acc) begin
        rd_ptr <= rd_ptr + QUEUE_IDX_W'(1);
      end
      if (in_acc) begin
        wr_ptr <= wr_ptr + QUEUE_IDX_W'(push_n);
        if (row_in.row_is_last) begin
          // Drop the history: the next row starts a new glyph.
          spread_prev1 <= '0;
          spread_prev2 <= '0;
          shifted_prev <= '0;
        end else begin
          spread_prev2 <= spread_prev1;
          spread_prev1 <= spread;
          shifted_prev <= shifted;
        end
      end
    end
  end

  // Queue payload: the row result at wr_ptr, the two flush rows after it.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      queue[wr_ptr].bits <= ROW_DATA_W'(res0);
      queue[wr_ptr].last <= 1'b0;
      if (row_in.row_is_last) begin
        queue[wr_ptr + QUEUE_IDX_W'(1)].bits <= ROW_DATA_W'(res1);
        queue[wr_ptr + QUEUE_IDX_W'(1)].last <= 1'b0;
        queue[wr_ptr + QUEUE_IDX_W'(2)].bits <= ROW_DATA_W'(res2);
        queue[wr_ptr + QUEUE_IDX_W'(2)].last <= 1'b1;
      end
    end
  end

  // The queue never overfills.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // A final row leaves at least its three results queued.
  a_flush_queued: assert property (@(posedge clk) disable iff (rst)
    in_acc && row_in.row_is_last |=> count >= QUEUE_CNT_W'(MAX_PUSH))
    else $error("flush rows not queued");

  // History is empty after a final row.
  a_history_cleared: assert property (@(posedge clk) disable iff (rst)
    in_acc && row_in.row_is_last |=>
      spread_prev1 == '0 && spread_prev2 == '0 && shifted_prev == '0)
    else $error("row history not cleared after final row");

  // Queue pointers stay a count apart.
  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    QUEUE_IDX_W'(wr_ptr - rd_ptr) == QUEUE_IDX_W'(count))
    else $error("queue pointers out of step with count");

endmodule
